@@ hdl/mpv_pkg.sv @@
`timescale 1ns / 1ps
// mpv_pkg: constants, request codes, controller command type and FNV-1a helpers
// for the Merkle proof verifier. No dependencies.
package mpv_pkg;

  localparam logic [63:0] FNV_OFFSET_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME        = 64'h00000100000001b3;
  localparam int          HEX_DIGITS       = 16;
  localparam int          STEP_ROUNDS      = 2 * HEX_DIGITS;
  localparam int          ROUND_CNT_W      = $clog2(STEP_ROUNDS);

  localparam logic [1:0] FUNC_LEAF   = 2'd0;
  localparam logic [1:0] FUNC_STEP   = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_A_M10 = 8'h57;

  typedef struct packed {
    logic leaf;
    logic load;
    logic hex_round;
    logic finish;
  } mpv_cmd_t;

  // h ^ b, then times the prime (2^40 + 0x1b3) as shift-add
  function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (ASCII_ZERO + {4'd0, n}) : (ASCII_A_M10 + {4'd0, n});
  endfunction

endpackage

@@ hdl/merkle_proof_verifier.sv @@
`timescale 1ns / 1ps
// merkle_proof_verifier: top level, Merkle inclusion proof check on 64-bit FNV-1a.
// Depends on mpv_pkg, mpv_ctrl and mpv_datapath.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   func, data_byte, sibling_hash,
//                                           sibling_is_left, expected_root, root_present
//   out_     output     out_valid/out_stall verified, computed_root
//
// A proof step is one load, then one hex-character round per nibble of the ordered
// hash pair, each round through the FNV fold.
// Reset (rst_n low, synchronous) sets the running hash to the offset basis.
// The result sits in an output register; while it is stalled, in_stall is high.
module merkle_proof_verifier import mpv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_data_byte,
  input  logic [63:0] in_sibling_hash,
  input  logic        in_sibling_is_left,
  input  logic [63:0] in_expected_root,
  input  logic        in_root_present,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_verified,
  output logic [63:0] out_computed_root
);

  mpv_cmd_t cmd;

  mpv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  mpv_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_data_byte       (in_data_byte),
    .in_sibling_hash    (in_sibling_hash),
    .in_sibling_is_left (in_sibling_is_left),
    .in_expected_root   (in_expected_root),
    .in_root_present    (in_root_present),
    .out_verified       (out_verified),
    .out_computed_root  (out_computed_root)
  );

endmodule

@@ hdl/mpv_datapath.sv @@
`timescale 1ns / 1ps
// mpv_datapath: running hash, pair shift register and result register.
// Depends on mpv_pkg; driven by commands from mpv_ctrl.
module mpv_datapath import mpv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  mpv_cmd_t    cmd,
  input  logic [7:0]  in_data_byte,
  input  logic [63:0] in_sibling_hash,
  input  logic        in_sibling_is_left,
  input  logic [63:0] in_expected_root,
  input  logic        in_root_present,
  output logic        out_verified,
  output logic [63:0] out_computed_root
);

  logic [63:0]  hash_r, hash_nxt;
  logic [127:0] pair_r, pair_nxt;
  logic         verified_r, verified_nxt;
  logic [63:0]  root_r, root_nxt;

  always_comb begin
    hash_nxt     = hash_r;
    pair_nxt     = pair_r;
    verified_nxt = verified_r;
    root_nxt     = root_r;
    if (cmd.leaf) begin
      hash_nxt = fnv_fold(hash_r, in_data_byte);
    end
    if (cmd.load) begin
      pair_nxt = in_sibling_is_left ? {in_sibling_hash, hash_r} : {hash_r, in_sibling_hash};
      hash_nxt = FNV_OFFSET_BASIS;
    end
    if (cmd.hex_round) begin
      hash_nxt = fnv_fold(hash_r, hex_char(pair_r[127:124]));
      pair_nxt = {pair_r[123:0], 4'd0};
    end
    if (cmd.finish) begin
      verified_nxt = in_root_present && (hash_r == in_expected_root);
      root_nxt     = hash_r;
      hash_nxt     = FNV_OFFSET_BASIS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= FNV_OFFSET_BASIS;
    end else begin
      hash_r <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pair_r     <= pair_nxt;
    verified_r <= verified_nxt;
    root_r     <= root_nxt;
  end

  assign out_verified      = verified_r;
  assign out_computed_root = root_r;

endmodule

@@ hdl/mpv_ctrl.sv @@
`timescale 1ns / 1ps
// mpv_ctrl: request handshake, proof-step round sequencer and result valid flag.
// Depends on mpv_pkg; commands mpv_datapath.
module mpv_ctrl import mpv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output mpv_cmd_t   cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_STEP = 1'b1;
  localparam logic [ROUND_CNT_W-1:0] LAST_ROUND = ROUND_CNT_W'(STEP_ROUNDS - 1);

  logic                   state_r, state_nxt;
  logic [ROUND_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   accept;

  assign in_stall = (state_r == ST_STEP) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd.leaf      = accept && (in_func == FUNC_LEAF);
    cmd.load      = accept && (in_func == FUNC_STEP);
    cmd.finish    = accept && (in_func == FUNC_FINISH);
    cmd.hex_round = (state_r == ST_STEP);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (cnt_r == LAST_ROUND) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + ROUND_CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r == '0))
    else $error("round counter nonzero while idle");

  a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_STEP) && (cnt_r == '0))
    else $error("proof step did not start round sequence");

  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finish request gave no result");

  a_no_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> !(cmd.leaf || cmd.load || cmd.finish))
    else $error("request taken during proof step");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for merkle_proof_verifier; a scoreboard tracks the
// FNV-1a running hash and checks every finish result. Depends on mpv_pkg and the dut.

typedef struct packed {
  logic [1:0]  func;
  logic [7:0]  data_byte;
  logic [63:0] sibling_hash;
  logic        sibling_is_left;
  logic [63:0] expected_root;
  logic        root_present;
} request_t;

class root_scoreboard;
  logic [63:0] running_hash;
  logic        verified_q[$];
  logic [63:0] root_q[$];
  int          errors;

  function new();
    running_hash = mpv_pkg::FNV_OFFSET_BASIS;
    errors = 0;
  endfunction

  function logic [63:0] fold_byte(logic [63:0] h, logic [7:0] b);
    return (h ^ {56'd0, b}) * mpv_pkg::FNV_PRIME;
  endfunction

  // lowercase hex digits, most significant nibble first
  function logic [63:0] fold_hex(logic [63:0] h, logic [63:0] v);
    logic [3:0] nib;
    logic [7:0] ch;
    for (int i = 0; i < 16; i++) begin
      nib = v[63:60];
      v = v << 4;
      ch = (nib < 4'd10) ? ("0" + {4'd0, nib}) : ("a" + {4'd0, nib} - 8'd10);
      h = fold_byte(h, ch);
    end
    return h;
  endfunction

  function void note_request(request_t r);
    logic [63:0] left_node;
    logic [63:0] right_node;
    case (r.func)
      mpv_pkg::FUNC_LEAF: running_hash = fold_byte(running_hash, r.data_byte);
      mpv_pkg::FUNC_STEP: begin
        left_node  = r.sibling_is_left ? r.sibling_hash : running_hash;
        right_node = r.sibling_is_left ? running_hash : r.sibling_hash;
        running_hash = fold_hex(fold_hex(mpv_pkg::FNV_OFFSET_BASIS, left_node), right_node);
      end
      mpv_pkg::FUNC_FINISH: begin
        verified_q = {verified_q, r.root_present && (running_hash == r.expected_root)};
        root_q = {root_q, running_hash};
        running_hash = mpv_pkg::FNV_OFFSET_BASIS;
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic verified, logic [63:0] root);
    logic        exp_verified;
    logic [63:0] exp_root;
    if (root_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result verified=%0b computed_root=%h", $time, verified, root);
      return;
    end
    exp_verified = verified_q.pop_front();
    exp_root = root_q.pop_front();
    if (verified !== exp_verified) begin
      errors++;
      $display("%0t: verified mismatch expected=%0b actual=%0b", $time, exp_verified, verified);
    end
    if (root !== exp_root) begin
      errors++;
      $display("%0t: computed_root mismatch expected=%h actual=%h", $time, exp_root, root);
    end
  endfunction

  function int pending();
    return root_q.size();
  endfunction
endclass

module testbench;
  import mpv_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 335;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = FUNC_LEAF;
  logic [7:0]  in_data_byte = 8'd0;
  logic [63:0] in_sibling_hash = 64'd0;
  logic        in_sibling_is_left = 1'b0;
  logic [63:0] in_expected_root = 64'd0;
  logic        in_root_present = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_verified;
  logic [63:0] out_computed_root;

  logic        out_hold = 1'b0;
  logic        pressure_on = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          items_sent = 0;
  int          cycles = 0;
  root_scoreboard board = new();

  merkle_proof_verifier dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_data_byte(in_data_byte),
    .in_sibling_hash(in_sibling_hash),
    .in_sibling_is_left(in_sibling_is_left),
    .in_expected_root(in_expected_root),
    .in_root_present(in_root_present),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_verified(out_verified),
    .out_computed_root(out_computed_root)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= out_hold || ($urandom_range(99) < recv_stall_pct);
  end

  // long receiver hold-off so the result register fills and backs up the input
  initial begin
    wait (pressure_on);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    out_hold <= 1'b0;
  end

  // values are stable from negedge to the next posedge, where the transfer happens
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(out_verified, out_computed_root);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.func = 2'($urandom_range(3));
    r.data_byte = 8'($urandom_range(255));
    r.sibling_hash = rand64();
    r.sibling_is_left = 1'($urandom_range(1));
    r.expected_root = rand64();
    r.root_present = 1'($urandom_range(1));
    return r;
  endfunction

  // entered and left at a rising edge
  task automatic send_request(request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= r.func;
    in_data_byte <= r.data_byte;
    in_sibling_hash <= r.sibling_hash;
    in_sibling_is_left <= r.sibling_is_left;
    in_expected_root <= r.expected_root;
    in_root_present <= r.root_present;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    board.note_request(r);
    if (r.func != FUNC_UNUSED) items_sent++;
  endtask

  task automatic send_leaf(logic [7:0] b);
    request_t r;
    r = random_request();
    r.func = FUNC_LEAF;
    r.data_byte = b;
    send_request(r);
  endtask

  task automatic send_step(logic [63:0] sib, logic sib_left);
    request_t r;
    r = random_request();
    r.func = FUNC_STEP;
    r.sibling_hash = sib;
    r.sibling_is_left = sib_left;
    send_request(r);
  endtask

  task automatic send_finish(logic [63:0] root, logic present);
    request_t r;
    r = random_request();
    r.func = FUNC_FINISH;
    r.expected_root = root;
    r.root_present = present;
    send_request(r);
  endtask

  // mostly the matching root, sometimes a near miss or a random one
  task automatic send_proof_finish();
    logic [63:0] root;
    logic [5:0]  flip_bit;
    root = board.running_hash;
    case ($urandom_range(5))
      0: begin
        flip_bit = 6'($urandom_range(63));
        root[flip_bit] = ~root[flip_bit];
      end
      1: root = rand64();
      default: ;
    endcase
    send_finish(root, $urandom_range(9) != 0);
  endtask

  task automatic run_random(int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(4) != 0) begin
        repeat ($urandom_range(6)) send_leaf(8'($urandom_range(255)));
        repeat ($urandom_range(4)) send_step(rand64(), 1'($urandom_range(1)));
        send_proof_finish();
      end else begin
        send_request(random_request());
      end
    end
  endtask

  initial begin
    request_t r;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_finish(FNV_OFFSET_BASIS, 1'b1);
    send_leaf(8'h00);
    send_leaf(8'hff);
    send_finish(board.running_hash, 1'b0);
    send_leaf(8'h61);
    send_step(64'd0, 1'b0);
    send_step({64{1'b1}}, 1'b1);
    send_finish(board.running_hash, 1'b1);
    r = random_request();
    r.func = FUNC_UNUSED;
    send_request(r);
    send_finish(board.running_hash, 1'b1);
    send_step(rand64(), 1'b1);
    send_leaf(8'h80);
    send_leaf(8'h7f);
    send_finish(64'd0, 1'b1);
    send_leaf(8'($urandom_range(255)));
    send_finish({64{1'b1}}, 1'b1);
    send_step(rand64(), 1'b0);
    send_finish(board.running_hash, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (board.pending() > 0) @(posedge clk);
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          pressure_on = 1'b1;
        end
        1: begin
          send_idle_pct = 83;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 83;
        end
        default: begin
          send_idle_pct = 15;
          recv_stall_pct = 15;
        end
      endcase
      run_random(ITEMS_PER_PHASE);
    end

    in_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
